@@ design/gzip_block_header_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// gzip block header parser assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GZIP_BLOCK_HEADER_PARSER_UNIT_ASSERT_SVH
`define GZIP_BLOCK_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GZBHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GZBHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GZBHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GZBHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/gzbhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gzbhp_pkg
// shared constants and types of the gzip block header parser
// ----------------------------------------------------------------------------
package gzbhp_pkg;

    localparam int COUNT_BITS    = 20;
    localparam int CAPTURE_BYTES = 12;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);

    localparam int HDR_LEN_W = 20;
    localparam int XLEN_W    = 16;
    localparam int BLK_W     = 32;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_METH  = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    // multi-block format kinds
    localparam logic [2:0] FK_BGZF  = 3'd0;
    localparam logic [2:0] FK_MZ    = 3'd1;
    localparam logic [2:0] FK_IG_V1 = 3'd2;
    localparam logic [2:0] FK_IG_V2 = 3'd3;
    localparam logic [2:0] FK_SIZE3 = 3'd4;

    // gzip header bytes and flag bits
    localparam logic [7:0] GZ_ID1       = 8'h1f;
    localparam logic [7:0] GZ_ID2       = 8'h8b;
    localparam logic [7:0] GZ_CM_DEFL   = 8'h08;
    localparam logic [7:0] FLG_RESERVED = 8'he0;
    localparam int         FLG_FHCRC    = 1;
    localparam int         FLG_FEXTRA   = 2;
    localparam int         FLG_FNAME    = 3;
    localparam int         FLG_FCOMMENT = 4;
    localparam int         FIXED_HDR    = 10;

    localparam logic [3:0] EXTRA_OFFSET = 4'd12;

    // extra field tags, first byte in the low bits
    localparam logic [31:0] TAG_BC    = 32'h0002_4342;
    localparam logic [31:0] TAG_MZ    = 32'h0004_5a4d;
    localparam logic [31:0] TAG_IG_V1 = 32'h0010_4749;
    localparam logic [31:0] TAG_IG_V2 = 32'h0004_4749;
    localparam logic [7:0]  SIZE3_TAG = 8'h7d;

    typedef struct packed {
        logic [2:0]           status;
        logic [2:0]           format_kind;
        logic [HDR_LEN_W-1:0] header_length;
        logic [3:0]           extra_offset;
        logic [XLEN_W-1:0]    extra_length;
        logic [BLK_W-1:0]     block_length;
    } result_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       format_kind;
        logic [BLK_W-1:0] block_length;
    } fmt_t;

endpackage

@@ design/gzip_block_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// gzip_block_header_parser_unit
// gzip member header parser that recognizes multi-block gzip formats
// ----------------------------------------------------------------------------
// Feed the header bytes of a gzip member one item per byte on the slave side,
// with tlast on the last byte available. The unit checks magic, method and
// reserved flags, walks the fixed part, the extra field (keeping its first 12
// bytes), name, comment and header crc, and gives one result per header on
// the master side: status and format kind in tuser, header length, extra
// offset, extra length and block length in tdata. A byte is taken in every
// cycle: each byte updates the walk state in a single combinational pass and
// a result lands in the output register on the clock edge of the byte that
// ends the header, so it is visible in the cycle after. The only stall comes
// from the single-entry output register: s_tready drops while it holds a
// result that m_tready does not take. After a result, bytes are dropped
// until tlast; the byte after tlast starts a new header. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module gzip_block_header_parser_unit
    import gzbhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [19:0] header_length, [23:20] extra_offset,
                                   // [39:24] extra_length, [71:40] block_length
    output logic [5:0]  m_tuser    // [2:0] status, [5:3] format_kind
);

`include "gzip_block_header_parser_unit_assert.svh"

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t res_q;
    logic    out_free;

    // byte taken whenever the result register can take what it may cause
    assign s_tready = out_free;
    assign accept   = s_tvalid && s_tready;

    gzbhp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata),
        .end_of_data (s_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    gzbhp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res_in   (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_out  (res_q),
        .free     (out_free)
    );

    assign m_tdata = {res_q.block_length, res_q.extra_length,
                      res_q.extra_offset, res_q.header_length};
    assign m_tuser = {res_q.format_kind, res_q.status};

    // a recognized format always comes from an extra field of its own size
    `GZBHP_ASSERT_IMP(a_ok_len, clk, rst_n,
        m_tvalid && m_tuser[2:0] == ST_OK,
        m_tdata[39:24] == 16'd4 || m_tdata[39:24] == 16'd6 ||
        m_tdata[39:24] == 16'd8 || m_tdata[39:24] == 16'd20,
        "ok result with an extra length no format uses")

    // failures carry no format and no block length
    `GZBHP_ASSERT_IMP(a_fail_zero, clk, rst_n,
        m_tvalid && m_tuser[2:0] != ST_OK,
        m_tuser[5:3] == FK_BGZF && m_tdata[71:40] == 32'd0,
        "failure result with format or block length")

    // the three-byte form holds only 24 bits of length
    `GZBHP_ASSERT_IMP(a_size3, clk, rst_n,
        m_tvalid && m_tuser[2:0] == ST_OK && m_tuser[5:3] == FK_SIZE3,
        m_tdata[39:24] == 16'd4 && m_tdata[71:64] == 8'd0,
        "three-byte form result out of shape")

    // a result taken with nothing new loaded leaves the output empty
    `GZBHP_ASSERT_NXT(a_drain, clk, rst_n,
        m_tvalid && m_tready && !res_valid,
        !m_tvalid,
        "result shown twice")

endmodule

@@ design/gzbhp_format_decode.sv @@
// ----------------------------------------------------------------------------
// gzbhp_format_decode
// names the multi-block format from the extra field and works out its length
// ----------------------------------------------------------------------------
module gzbhp_format_decode
    import gzbhp_pkg::*;
(
    input  logic [63:0]           cap_lo,       // extra bytes 0..7, byte 0 lowest
    input  logic [XLEN_W-1:0]     extra_total,
    input  logic [COUNT_BITS-1:0] byte_count,
    output fmt_t                  fmt
);

    logic [31:0] tag;
    logic [31:0] word1;

    assign tag   = cap_lo[31:0];
    assign word1 = cap_lo[63:32];

    always_comb
    begin
        fmt.status       = ST_UNKNOWN;
        fmt.format_kind  = FK_BGZF;
        fmt.block_length = '0;
        if (extra_total == XLEN_W'(6) && tag == TAG_BC)
        begin
            fmt.status       = ST_OK;
            fmt.format_kind  = FK_BGZF;
            fmt.block_length = BLK_W'(word1[15:0]) + BLK_W'(1);
        end
        else if (extra_total == XLEN_W'(8) && tag == TAG_MZ)
        begin
            fmt.status       = ST_OK;
            fmt.format_kind  = FK_MZ;
            fmt.block_length = word1 + BLK_W'(byte_count) + BLK_W'(8);
        end
        else if (extra_total == XLEN_W'(20) && tag == TAG_IG_V1)
        begin
            fmt.status       = ST_OK;
            fmt.format_kind  = FK_IG_V1;
            fmt.block_length = word1;
        end
        else if (extra_total == XLEN_W'(8) && tag == TAG_IG_V2)
        begin
            fmt.status       = ST_OK;
            fmt.format_kind  = FK_IG_V2;
            fmt.block_length = word1;
        end
        else if (extra_total == XLEN_W'(4) && tag[31:24] == SIZE3_TAG)
        begin
            fmt.status       = ST_OK;
            fmt.format_kind  = FK_SIZE3;
            fmt.block_length = {8'h00, tag[23:0]};
        end
    end

endmodule

@@ design/gzbhp_parse_core.sv @@
// ----------------------------------------------------------------------------
// gzbhp_parse_core
// header walk state and per-byte update, one byte per accepted item
// ----------------------------------------------------------------------------
module gzbhp_parse_core
    import gzbhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic [7:0] data_byte,
    input  logic    end_of_data,
    output logic    res_valid,
    output result_t res
);

    localparam logic [3:0] PH_MAGIC1  = 4'd0;
    localparam logic [3:0] PH_MAGIC2  = 4'd1;
    localparam logic [3:0] PH_METHOD  = 4'd2;
    localparam logic [3:0] PH_FLAGS   = 4'd3;
    localparam logic [3:0] PH_SKIP    = 4'd4;
    localparam logic [3:0] PH_XLO     = 4'd5;
    localparam logic [3:0] PH_XHI     = 4'd6;
    localparam logic [3:0] PH_EXTRA   = 4'd7;
    localparam logic [3:0] PH_NAME    = 4'd8;
    localparam logic [3:0] PH_COMMENT = 4'd9;
    localparam logic [3:0] PH_CRC1    = 4'd10;
    localparam logic [3:0] PH_CRC2    = 4'd11;
    localparam logic [3:0] PH_DONE    = 4'd12;
    localparam logic [3:0] PH_FIN     = 4'd13;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [3:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [7:0]            flags_reg, flags_next;
    logic [XLEN_W-1:0]     xtot_reg, xtot_next;
    logic [XLEN_W-1:0]     xseen_reg, xseen_next;
    logic [7:0]            cap_reg [CAPTURE_BYTES];

    logic                  cap_we;
    logic [CAP_IDX_W-1:0]  cap_idx;
    logic [63:0]           cap_lo;
    logic [COUNT_BITS-1:0] bc;
    logic [3:0]            ph;
    logic [7:0]            flg;
    logic [XLEN_W-1:0]     xt;
    logic [XLEN_W-1:0]     xs;
    logic                  err_hit;
    logic [2:0]            err_code;
    fmt_t                  fmt;

    function automatic logic [3:0] after_comment(input logic [7:0] f);
        return f[FLG_FHCRC] ? PH_CRC1 : PH_FIN;
    endfunction

    function automatic logic [3:0] after_name(input logic [7:0] f);
        return f[FLG_FCOMMENT] ? PH_COMMENT : after_comment(f);
    endfunction

    function automatic logic [3:0] after_extra(input logic [7:0] f);
        return f[FLG_FNAME] ? PH_NAME : after_name(f);
    endfunction

    // extra bytes as seen after this item's write
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            cap_lo[8*k +: 8] = (cap_we && cap_idx == CAP_IDX_W'(k)) ? data_byte : cap_reg[k];
        end
    end

    gzbhp_format_decode u_decode (
        .cap_lo      (cap_lo),
        .extra_total (xt),
        .byte_count  (bc),
        .fmt         (fmt)
    );

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        flags_next = flags_reg;
        xtot_next  = xtot_reg;
        xseen_next = xseen_reg;
        cap_we     = 1'b0;
        cap_idx    = xseen_reg[CAP_IDX_W-1:0];
        bc         = count_reg + COUNT_BITS'(1);
        ph         = phase_reg;
        flg        = flags_reg;
        xt         = xtot_reg;
        xs         = xseen_reg;
        err_hit    = 1'b0;
        err_code   = ST_OK;
        res_valid  = 1'b0;
        res.status        = ST_OK;
        res.format_kind   = FK_BGZF;
        res.header_length = HDR_LEN_W'(bc);
        res.extra_offset  = EXTRA_OFFSET;
        res.extra_length  = xtot_reg;
        res.block_length  = '0;

        if (accept)
        begin
            if (phase_reg == PH_DONE)
            begin
                // waiting for the end marker after a result
                if (end_of_data)
                begin
                    phase_next = PH_MAGIC1;
                    count_next = '0;
                    flags_next = '0;
                    xtot_next  = '0;
                    xseen_next = '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC1:
                    begin
                        if (data_byte != GZ_ID1)
                        begin
                            err_hit  = 1'b1;
                            err_code = ST_BAD_MAGIC;
                        end
                        else
                        begin
                            ph = PH_MAGIC2;
                        end
                    end
                    PH_MAGIC2:
                    begin
                        if (data_byte != GZ_ID2)
                        begin
                            err_hit  = 1'b1;
                            err_code = ST_BAD_MAGIC;
                        end
                        else
                        begin
                            ph = PH_METHOD;
                        end
                    end
                    PH_METHOD:
                    begin
                        if (data_byte != GZ_CM_DEFL)
                        begin
                            err_hit  = 1'b1;
                            err_code = ST_BAD_METH;
                        end
                        else
                        begin
                            ph = PH_FLAGS;
                        end
                    end
                    PH_FLAGS:
                    begin
                        flg = data_byte;
                        if ((data_byte & FLG_RESERVED) != 8'h00)
                        begin
                            err_hit  = 1'b1;
                            err_code = ST_BAD_METH;
                        end
                        else
                        begin
                            ph = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        // mtime, xfl, os
                        if (bc == COUNT_BITS'(FIXED_HDR))
                        begin
                            ph = flg[FLG_FEXTRA] ? PH_XLO : after_extra(flg);
                        end
                    end
                    PH_XLO:
                    begin
                        xt = {8'h00, data_byte};
                        ph = PH_XHI;
                    end
                    PH_XHI:
                    begin
                        xt = {data_byte, xtot_reg[7:0]};
                        xs = '0;
                        ph = (xt != '0) ? PH_EXTRA : after_extra(flg);
                    end
                    PH_EXTRA:
                    begin
                        if (xseen_reg < XLEN_W'(CAPTURE_BYTES))
                        begin
                            cap_we = 1'b1;
                        end
                        xs = xseen_reg + XLEN_W'(1);
                        if (xs >= xtot_reg)
                        begin
                            ph = after_extra(flg);
                        end
                    end
                    PH_NAME:
                    begin
                        if (data_byte == 8'h00)
                        begin
                            ph = after_name(flg);
                        end
                    end
                    PH_COMMENT:
                    begin
                        if (data_byte == 8'h00)
                        begin
                            ph = after_comment(flg);
                        end
                    end
                    PH_CRC1:
                    begin
                        ph = PH_CRC2;
                    end
                    default:
                    begin
                        ph = PH_FIN;
                    end
                endcase

                res.extra_length = xt;

                if (err_hit)
                begin
                    res_valid  = 1'b1;
                    res.status = err_code;
                end
                else if (ph == PH_FIN)
                begin
                    res_valid        = 1'b1;
                    res.status       = fmt.status;
                    res.format_kind  = fmt.format_kind;
                    res.block_length = fmt.block_length;
                end
                else if (end_of_data)
                begin
                    res_valid = 1'b1;
                    // running out inside name or comment closes the header unless a crc follows
                    if ((ph == PH_NAME || ph == PH_COMMENT) && !flg[FLG_FHCRC])
                    begin
                        res.status       = fmt.status;
                        res.format_kind  = fmt.format_kind;
                        res.block_length = fmt.block_length;
                    end
                    else
                    begin
                        res.status = ST_TRUNC;
                    end
                end
                else if (bc == COUNT_MAX)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_TOO_LONG;
                end

                phase_next = res_valid ? PH_DONE : ph;
                count_next = bc;
                flags_next = flg;
                xtot_next  = xt;
                xseen_next = xs;

                if (end_of_data)
                begin
                    phase_next = PH_MAGIC1;
                    count_next = '0;
                    flags_next = '0;
                    xtot_next  = '0;
                    xseen_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC1;
            count_reg <= '0;
            flags_reg <= '0;
            xtot_reg  <= '0;
            xseen_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
            xtot_reg  <= xtot_next;
            xseen_reg <= xseen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_reg[cap_idx] <= data_byte;
        end
    end

endmodule

@@ design/gzbhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// gzbhp_out_stage
// result register with valid/ready toward the downstream side
// ----------------------------------------------------------------------------
module gzbhp_out_stage
    import gzbhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    m_tready,
    output logic    m_tvalid,
    output result_t res_out,
    output logic    free
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // room when empty or when the held result leaves this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

@@ tb/sv/gzip_block_header_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// gzip_block_header_parser_unit_test
// self-checking bench for the gzip member header parser
// ----------------------------------------------------------------------------
// Header byte streams are queued by a stimulus process and played out by a
// clocked driver with random gaps. A clocked monitor predicts the result of
// each accepted byte with its own copy of the header walk. It then checks
// every result field by field against the oldest prediction. The stream
// opens with hand-built headers for each format, extreme block lengths,
// the error codes and early ends. Random headers follow: mostly well formed,
// some corrupted, some noise.
// ----------------------------------------------------------------------------
module gzip_block_header_parser_unit_test;
    import gzbhp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int LONG_HOLD    = 300;   // receiver hold-off used once
    localparam int FEED_DEPTH   = 64;    // bytes queued ahead of the driver
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_FILL  = -1;
    localparam int FLG_FTEXT    = 0;

    // extra field lengths of the recognized formats
    localparam int LEN_BC    = 6;
    localparam int LEN_MZ    = 8;
    localparam int LEN_IG_V1 = 20;
    localparam int LEN_IG_V2 = 8;
    localparam int LEN_SIZE3 = 4;
    localparam logic [31:0] MZ_BLOCK_BIAS = 32'd8;

    // position of the header walk
    typedef enum logic [3:0] {
        W_ID1, W_ID2, W_CM, W_FLG, W_FIXED, W_XLEN_LO, W_XLEN_HI, W_XDATA,
        W_NAME, W_COMMENT, W_HCRC_LO, W_HCRC_HI, W_DONE, W_END
    } walk_t;

    // shape of the extra field in generated headers
    typedef enum int {
        EX_BGZF, EX_MZ, EX_IG_V1, EX_IG_V2, EX_SIZE3, EX_RANDOM, EX_EMPTY, EX_NONE
    } extra_style_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;   // [19:0] header_length, [23:20] extra_offset,
                            // [39:24] extra_length, [71:40] block_length
    logic [5:0]  m_tuser;   // [2:0] status, [5:3] format_kind

    gzip_block_header_parser_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // bench bookkeeping
    feed_item_t byte_feed[$];
    result_t    results_due[$];
    logic [7:0] frame[$];
    bit         in_taken = 1'b0;
    bit         idle_mode = 1'b1;
    int         send_gap = 0;
    int         sink_gap = 0;
    int         hold_asked = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    int         pushed_count = 0;
    int         accepted_count = 0;
    int         header_items = 0;
    int         results_checked = 0;
    int         quiet_cycles = 0;
    int         fail_count = 0;
    int         status_seen[8];
    int         kind_seen[8];

    // predicted walk state
    walk_t                  walk;
    logic [COUNT_BITS-1:0]  hdr_count;
    logic [7:0]             hdr_flags;
    logic [XLEN_W-1:0]      xlen;
    logic [XLEN_W-1:0]      xseen;
    logic [7:0]             xcap[CAPTURE_BYTES];
    bit                     reported;

    function automatic void start_header_walk();
        walk = W_ID1;
        hdr_count = '0;
        hdr_flags = '0;
        xlen = '0;
        xseen = '0;
        reported = 1'b0;
    endfunction

    // section that follows the one just closed, skipping absent ones
    function automatic walk_t next_section(input walk_t closed);
        if (closed == W_XDATA && hdr_flags[FLG_FNAME])
            return W_NAME;
        if (closed != W_COMMENT && hdr_flags[FLG_FCOMMENT])
            return W_COMMENT;
        if (hdr_flags[FLG_FHCRC])
            return W_HCRC_LO;
        return W_END;
    endfunction

    function automatic result_t report(input logic [2:0] st, input logic [2:0] kind,
                                       input logic [31:0] blk);
        result_t r;
        r.status        = st;
        r.format_kind   = kind;
        r.header_length = hdr_count;
        r.extra_offset  = EXTRA_OFFSET;
        r.extra_length  = xlen;
        r.block_length  = blk;
        reported = 1'b1;
        walk = W_DONE;
        return r;
    endfunction

    // format detection from the captured extra bytes
    function automatic result_t header_verdict();
        logic [31:0] tag;
        logic [31:0] word;
        tag  = {xcap[3], xcap[2], xcap[1], xcap[0]};
        word = {xcap[7], xcap[6], xcap[5], xcap[4]};
        if (xlen == XLEN_W'(LEN_BC) && tag == TAG_BC)
            return report(ST_OK, FK_BGZF, {16'h0000, xcap[5], xcap[4]} + 32'd1);
        if (xlen == XLEN_W'(LEN_MZ) && tag == TAG_MZ)
            return report(ST_OK, FK_MZ, word + {12'h000, hdr_count} + MZ_BLOCK_BIAS);
        if (xlen == XLEN_W'(LEN_IG_V1) && tag == TAG_IG_V1)
            return report(ST_OK, FK_IG_V1, word);
        if (xlen == XLEN_W'(LEN_IG_V2) && tag == TAG_IG_V2)
            return report(ST_OK, FK_IG_V2, word);
        if (xlen == XLEN_W'(LEN_SIZE3) && xcap[3] == SIZE3_TAG)
            return report(ST_OK, FK_SIZE3, {8'h00, xcap[2], xcap[1], xcap[0]});
        return report(ST_UNKNOWN, FK_BGZF, '0);
    endfunction

    // one accepted byte; returns 1 when it produces a result
    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output result_t r);
        walk_t      nxt;
        logic [2:0] err;
        bit         failed;
        bit         made;
        r = '0;
        err = ST_OK;
        failed = 1'b0;
        nxt = walk;
        // after a result everything up to the end marker is dropped
        if (reported || walk == W_DONE || walk == W_END)
        begin
            if (last)
                start_header_walk();
            else
                walk = W_DONE;
            return 1'b0;
        end
        hdr_count = hdr_count + COUNT_BITS'(1);
        case (walk)
            W_ID1:
            begin
                if (b != GZ_ID1)
                begin
                    failed = 1'b1;
                    err = ST_BAD_MAGIC;
                end
                else
                    nxt = W_ID2;
            end
            W_ID2:
            begin
                if (b != GZ_ID2)
                begin
                    failed = 1'b1;
                    err = ST_BAD_MAGIC;
                end
                else
                    nxt = W_CM;
            end
            W_CM:
            begin
                if (b != GZ_CM_DEFL)
                begin
                    failed = 1'b1;
                    err = ST_BAD_METH;
                end
                else
                    nxt = W_FLG;
            end
            W_FLG:
            begin
                hdr_flags = b;
                if ((b & FLG_RESERVED) != '0)
                begin
                    failed = 1'b1;
                    err = ST_BAD_METH;
                end
                else
                    nxt = W_FIXED;
            end
            W_FIXED:
            begin
                if (hdr_count == COUNT_BITS'(FIXED_HDR))
                    nxt = hdr_flags[FLG_FEXTRA] ? W_XLEN_LO : next_section(W_XDATA);
            end
            W_XLEN_LO:
            begin
                xlen = {8'h00, b};
                nxt = W_XLEN_HI;
            end
            W_XLEN_HI:
            begin
                xlen[15:8] = b;
                xseen = '0;
                nxt = (xlen != '0) ? W_XDATA : next_section(W_XDATA);
            end
            W_XDATA:
            begin
                if (xseen < XLEN_W'(CAPTURE_BYTES))
                    xcap[xseen[CAP_IDX_W-1:0]] = b;
                xseen = xseen + XLEN_W'(1);
                if (xseen >= xlen)
                    nxt = next_section(W_XDATA);
            end
            W_NAME:    if (b == 8'h00) nxt = next_section(W_NAME);
            W_COMMENT: if (b == 8'h00) nxt = next_section(W_COMMENT);
            W_HCRC_LO: nxt = W_HCRC_HI;
            default:   nxt = W_END;
        endcase

        made = 1'b1;
        if (failed)
            r = report(err, FK_BGZF, '0);
        else if (nxt == W_END)
            r = header_verdict();
        else if (last)
        begin
            // data ending in name or comment closes the header unless a crc follows
            if ((nxt == W_NAME || nxt == W_COMMENT) && !hdr_flags[FLG_FHCRC])
                r = header_verdict();
            else
                r = report(ST_TRUNC, FK_BGZF, '0);
        end
        else if (hdr_count == '1)
            r = report(ST_TOO_LONG, FK_BGZF, '0);
        else
        begin
            walk = nxt;
            made = 1'b0;
        end
        if (last)
            start_header_walk();
        return made;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // input driver: new item at the falling edge once the old one is taken
    always @(negedge clk)
    begin : feed_driver
        feed_item_t it;
        if (!s_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (byte_feed.size() > 0)
            begin
                it = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.data;
                s_tlast  <= it.last;
                if (idle_mode && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin : result_sink
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap--;
        end
        else if (idle_mode && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap = $urandom_range(0, 14);
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check results first, then predict the byte taken this edge
    always @(posedge clk)
    begin : monitor
        result_t seen;
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            start_header_walk();
            foreach (xcap[i])
                xcap[i] = '0;
        end
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (m_tvalid && m_tready)
            begin
                seen.status        = m_tuser[2:0];
                seen.format_kind   = m_tuser[5:3];
                seen.header_length = m_tdata[19:0];
                seen.extra_offset  = m_tdata[23:20];
                seen.extra_length  = m_tdata[39:24];
                seen.block_length  = m_tdata[71:40];
                results_checked++;
                if (results_due.size() == 0)
                begin
                    $error("result with none pending: status %0d, header_length %0d",
                           seen.status, seen.header_length);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("format_kind", 32'(want.format_kind),
                                32'(seen.format_kind));
                    check_field("header_length", 32'(want.header_length),
                                32'(seen.header_length));
                    check_field("extra_offset", 32'(want.extra_offset),
                                32'(seen.extra_offset));
                    check_field("extra_length", 32'(want.extra_length),
                                32'(seen.extra_length));
                    check_field("block_length", want.block_length, seen.block_length);
                    status_seen[want.status]++;
                    if (want.status == ST_OK)
                        kind_seen[want.format_kind]++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (predict_byte(s_tdata, s_tlast, pred))
                    results_due.push_back(pred);
                accepted_count++;
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_item(input logic [7:0] data, input logic last);
        feed_item_t it;
        it.data = data;
        it.last = last;
        while (byte_feed.size() >= FEED_DEPTH)
            @(negedge clk);
        byte_feed.push_back(it);
        pushed_count++;
    endtask

    // hold the sender until every byte is taken and every result is back
    task automatic wait_idle();
        while (accepted_count != pushed_count || results_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick(input int fill);
        logic [7:0] v;
        if (fill < 0)
            v = 8'($urandom_range(0, 255));
        else
            v = fill[7:0];
        return v;
    endfunction

    function automatic logic [7:0] flag_set(input bit name_on, input bit comment_on,
                                            input bit crc_on);
        logic [7:0] f;
        f = '0;
        f[FLG_FNAME]    = name_on;
        f[FLG_FCOMMENT] = comment_on;
        f[FLG_FHCRC]    = crc_on;
        return f;
    endfunction

    task automatic add_tag(input logic [31:0] tag);
        frame.push_back(tag[7:0]);
        frame.push_back(tag[15:8]);
        frame.push_back(tag[23:16]);
        frame.push_back(tag[31:24]);
    endtask

    // complete header in frame; the extra flag follows from the style
    task automatic build_frame(input extra_style_t style, input logic [7:0] flg,
                               input int name_len, input int comment_len,
                               input int fill, input int rand_len);
        logic [7:0] f;
        logic [7:0] v;
        int         xl;
        int         body_from;
        int         i;
        f = flg;
        f[FLG_FEXTRA] = (style != EX_NONE);
        xl = 0;
        body_from = 0;
        frame.delete();
        frame.push_back(GZ_ID1);
        frame.push_back(GZ_ID2);
        frame.push_back(GZ_CM_DEFL);
        frame.push_back(f);
        repeat (FIXED_HDR - 4)
            frame.push_back(pick(RANDOM_FILL));
        if (f[FLG_FEXTRA])
        begin
            case (style)
                EX_BGZF:   xl = LEN_BC;
                EX_MZ:     xl = LEN_MZ;
                EX_IG_V1:  xl = LEN_IG_V1;
                EX_IG_V2:  xl = LEN_IG_V2;
                EX_SIZE3:  xl = LEN_SIZE3;
                EX_RANDOM: xl = rand_len;
                default:   xl = 0;
            endcase
            frame.push_back(xl[7:0]);
            frame.push_back(xl[15:8]);
            body_from = 4;
            case (style)
                EX_BGZF:  add_tag(TAG_BC);
                EX_MZ:    add_tag(TAG_MZ);
                EX_IG_V1: add_tag(TAG_IG_V1);
                EX_IG_V2: add_tag(TAG_IG_V2);
                default:  body_from = 0;
            endcase
            for (i = body_from; i < xl; i++)
                frame.push_back((style == EX_SIZE3 && i == 3) ? SIZE3_TAG : pick(fill));
        end
        if (f[FLG_FNAME])
        begin
            repeat (name_len)
            begin
                v = 8'($urandom_range(1, 255));
                frame.push_back(v);
            end
            frame.push_back(8'h00);
        end
        if (f[FLG_FCOMMENT])
        begin
            repeat (comment_len)
            begin
                v = 8'($urandom_range(1, 255));
                frame.push_back(v);
            end
            frame.push_back(8'h00);
        end
        if (f[FLG_FHCRC])
        begin
            frame.push_back(pick(RANDOM_FILL));
            frame.push_back(pick(RANDOM_FILL));
        end
    endtask

    // send the first keep bytes (all when keep is 0) with tlast on the final
    // byte; a complete frame gets tail payload bytes that the block drops
    task automatic send_frame(input int keep, input int tail);
        int n;
        int i;
        n = (keep > 0 && keep < frame.size()) ? keep : frame.size();
        for (i = 0; i < n; i++)
            push_item(frame[i], i == n - 1 && (n < frame.size() || tail == 0));
        if (n == frame.size())
            for (i = 0; i < tail; i++)
                push_item(pick(RANDOM_FILL), i == tail - 1);
        header_items += n;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        extra_style_t style;
        logic [7:0]   flg;
        int           sel;
        int           idx;
        int           n;
        int           i;
        int           base;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // each format with its block length at the extremes
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, 8'hff, 0);  send_frame(0, 0);
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, 8'h00, 0);  send_frame(0, 2);
        build_frame(EX_MZ, flag_set(0, 0, 0), 0, 0, 8'hff, 0);    send_frame(0, 1);
        build_frame(EX_IG_V1, flag_set(0, 0, 0), 0, 0, 8'hff, 0); send_frame(0, 0);
        build_frame(EX_IG_V2, flag_set(0, 0, 0), 0, 0, 8'h00, 0); send_frame(0, 3);
        build_frame(EX_SIZE3, flag_set(0, 0, 0), 0, 0, 8'hff, 0); send_frame(0, 0);
        // every optional section present, ftext set too
        build_frame(EX_MZ, flag_set(1, 1, 1) | 8'h01, 3, 2, RANDOM_FILL, 0);
        send_frame(0, 1);
        // extra flag with zero length, and no extra field at all
        build_frame(EX_EMPTY, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0); send_frame(0, 0);
        build_frame(EX_NONE, flag_set(1, 0, 0), 4, 0, RANDOM_FILL, 0);  send_frame(0, 0);
        // bad magic in either byte, bad method, reserved flag bits
        push_item(~GZ_ID1, 1'b1);
        header_items++;
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        frame[1] = ~GZ_ID2;
        send_frame(0, 2);
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        frame[2] = GZ_CM_DEFL ^ 8'h0f;
        send_frame(0, 1);
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        frame[3] = frame[3] | FLG_RESERVED;
        send_frame(0, 0);
        // data ending inside the name closes the header
        build_frame(EX_BGZF, flag_set(1, 0, 0), 5, 0, RANDOM_FILL, 0);
        send_frame(20, 0);
        // inside the comment with a crc still to come is truncated
        build_frame(EX_NONE, flag_set(0, 1, 1), 0, 4, RANDOM_FILL, 0);
        send_frame(12, 0);
        // early ends in the fixed part and in the extra field
        build_frame(EX_IG_V1, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        send_frame(6, 0);
        build_frame(EX_IG_V1, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        send_frame(20, 0);
        // extra field well past the capture window
        build_frame(EX_RANDOM, flag_set(0, 0, 0), 0, 0, 8'hff, 40);
        send_frame(0, 0);
        wait_idle();

        // long receiver hold-off while short error headers keep coming
        hold_asked++;
        for (i = 0; i < 20; i++)
        begin
            push_item(~GZ_ID1, 1'b1);
            header_items++;
        end
        build_frame(EX_BGZF, flag_set(0, 0, 0), 0, 0, RANDOM_FILL, 0);
        send_frame(0, 0);
        wait_idle();

        // random headers, idling switched on and off in stretches
        base = header_items;
        while (header_items - base < RANDOM_ITEMS)
        begin
            if (header_items - base >= RANDOM_ITEMS * 4 / 5)
                idle_mode = 1'b0;
            else if ($urandom_range(0, 11) == 0)
                idle_mode = !idle_mode;

            sel = $urandom_range(0, 19);
            style = extra_style_t'($urandom_range(0, 7));
            flg = flag_set($urandom_range(0, 9) < 3, $urandom_range(0, 9) < 2,
                           $urandom_range(0, 3) == 0);
            flg[FLG_FTEXT] = 1'($urandom_range(0, 1));
            if (sel < 17)
                build_frame(style, flg, $urandom_range(0, 5), $urandom_range(0, 5),
                            RANDOM_FILL, $urandom_range(1, 24));
            if (sel < 14)
            begin
                // well formed, sometimes cut short
                if ($urandom_range(0, 6) == 0)
                    send_frame($urandom_range(1, frame.size()), 0);
                else
                    send_frame(0, $urandom_range(0, 3));
            end
            else if (sel < 17)
            begin
                // corrupt magic, method or flags
                idx = $urandom_range(0, 3);
                frame[idx] = frame[idx] ^ pick($urandom_range(1, 255));
                send_frame(0, $urandom_range(0, 3));
            end
            else
            begin
                // raw noise with scattered end markers
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    push_item(pick(RANDOM_FILL), i == n - 1 || $urandom_range(0, 7) == 0);
                header_items += n;
            end
            if ($urandom_range(0, 24) == 0)
                wait_idle();
        end
        idle_mode = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d header bytes and %0d results: ok %0d, bad magic %0d,",
                 header_items, results_checked, status_seen[ST_OK], status_seen[ST_BAD_MAGIC]);
        $display("bad method %0d, truncated %0d, unknown %0d, too long %0d; kinds %0d %0d %0d %0d %0d",
                 status_seen[ST_BAD_METH], status_seen[ST_TRUNC], status_seen[ST_UNKNOWN],
                 status_seen[ST_TOO_LONG], kind_seen[FK_BGZF], kind_seen[FK_MZ],
                 kind_seen[FK_IG_V1], kind_seen[FK_IG_V2], kind_seen[FK_SIZE3]);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
